// ----- rtl/core/sdrs_pkg.sv -----
// sdrs_pkg: shared types and constants for the serpentine dwell raster scan unit.
// No dependencies; imported by every module under rtl/core.
package sdrs_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int COUNT_BITS  = 13;
	localparam int PIXEL_BITS  = 4;
	localparam int POS_BITS    = 10;
	localparam int BPL_BITS    = 11;
	localparam int LINE_BITS   = 12;
	localparam int REG_IDX_BITS = 3;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_BITS-1:0]  count_t;

	localparam sample_t SAMPLE_MAX  = sample_t'((1 << SAMPLE_BITS) - 1);
	localparam count_t  MAX_SAMPLES = count_t'(4096);
	localparam logic [BPL_BITS-1:0] BPL_MAX = BPL_BITS'(1024);

	// configuration register indexes
	typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
	localparam reg_idx_t REG_LOW_X            = 3'd0;
	localparam reg_idx_t REG_HIGH_X           = 3'd1;
	localparam reg_idx_t REG_STEP_X           = 3'd2;
	localparam reg_idx_t REG_HIGH_Y           = 3'd3;
	localparam reg_idx_t REG_STEP_Y           = 3'd4;
	localparam reg_idx_t REG_BYTES_PER_LINE   = 3'd5;
	localparam reg_idx_t REG_LINES_PER_FRAME  = 3'd6;
	localparam reg_idx_t REG_SAMPLES_PER_LINE = 3'd7;

	typedef struct packed {
		sample_t                low_x;
		sample_t                high_x;
		sample_t                step_x;
		sample_t                high_y;
		sample_t                step_y;
		logic [BPL_BITS-1:0]    bytes_per_line;
		logic [LINE_BITS-1:0]   lines_per_frame;
		count_t                 samples_per_line;
	} cfg_t;

	// one result beat
	typedef struct packed {
		sample_t x_sample;
		sample_t y_sample;
		count_t  repeat_count;
		logic    is_padding;
		logic    frame_start;
		logic    overflow;
		logic    last;
	} run_t;

	// x after one pixel: up and saturate on left-to-right, down to zero otherwise
	function automatic sample_t step_x_fn(sample_t x, sample_t step, logic ltr);
		logic [SAMPLE_BITS:0] sum;
		sample_t              res;
		sum = {1'b0, x} + {1'b0, step};
		if (ltr) begin
			res = (sum > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : sum[SAMPLE_BITS-1:0];
		end else begin
			res = (x > step) ? sample_t'(x - step) : '0;
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/sdrs_cfg_regs.sv -----
// sdrs_cfg_regs: configuration register file, written one beat at a time.
// Depends on sdrs_pkg.
module sdrs_cfg_regs
	import sdrs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	input  reg_idx_t cfg_index,
	input  count_t   cfg_data,
	output cfg_t     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_x            <= '0;
			cfg_q.high_x           <= SAMPLE_MAX;
			cfg_q.step_x           <= sample_t'(32);
			cfg_q.high_y           <= SAMPLE_MAX;
			cfg_q.step_y           <= sample_t'(32);
			cfg_q.bytes_per_line   <= BPL_BITS'(64);
			cfg_q.lines_per_frame  <= LINE_BITS'(128);
			cfg_q.samples_per_line <= count_t'(1024);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOW_X:            cfg_q.low_x            <= cfg_data[SAMPLE_BITS-1:0];
				REG_HIGH_X:           cfg_q.high_x           <= cfg_data[SAMPLE_BITS-1:0];
				REG_STEP_X:           cfg_q.step_x           <= cfg_data[SAMPLE_BITS-1:0];
				REG_HIGH_Y:           cfg_q.high_y           <= cfg_data[SAMPLE_BITS-1:0];
				REG_STEP_Y:           cfg_q.step_y           <= cfg_data[SAMPLE_BITS-1:0];
				REG_BYTES_PER_LINE:   cfg_q.bytes_per_line   <= cfg_data[BPL_BITS-1:0];
				REG_LINES_PER_FRAME:  cfg_q.lines_per_frame  <= cfg_data[LINE_BITS-1:0];
				REG_SAMPLES_PER_LINE: cfg_q.samples_per_line <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/sdrs_run_core.sv -----
// sdrs_run_core: scan state and the single-pass run computation for one byte.
// Depends on sdrs_pkg.
module sdrs_run_core
	import sdrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        load,
	input  logic [7:0]  pix,
	output run_t [2:0]  runs,
	output logic        has_pad
);

	logic [POS_BITS-1:0]  pos_q;
	count_t               used_q;
	sample_t              x_q;
	sample_t              y_q;
	logic [LINE_BITS-1:0] line_q;
	logic                 ltr_q;

	logic [BPL_BITS-1:0]  bpl;
	logic [BPL_BITS-1:0]  pos_inc;
	logic                 line_done;
	count_t               lim;
	count_t               room0, room1, room2;
	count_t               n0, n1, c0, c1;
	logic                 ov0, ov1;
	sample_t              x1, x2;
	logic [LINE_BITS-1:0] lpf;
	logic [LINE_BITS-1:0] line_inc;
	logic                 wrap;
	sample_t              y_next;

	always_comb begin
		if (cfg.bytes_per_line == '0) begin
			bpl = BPL_BITS'(1);
		end else if (cfg.bytes_per_line > BPL_MAX) begin
			bpl = BPL_MAX;
		end else begin
			bpl = cfg.bytes_per_line;
		end
		pos_inc   = {1'b0, pos_q} + BPL_BITS'(1);
		line_done = (pos_inc >= bpl);

		lim   = (cfg.samples_per_line > MAX_SAMPLES) ? MAX_SAMPLES : cfg.samples_per_line;
		room0 = (used_q >= lim) ? '0 : count_t'(lim - used_q);

		// run cut to what is left in the line
		n0    = count_t'(pix[PIXEL_BITS-1:0]);
		n1    = count_t'(pix[4 +: PIXEL_BITS]);
		ov0   = (n0 > room0);
		c0    = ov0 ? room0 : n0;
		room1 = room0 - c0;
		ov1   = (n1 > room1);
		c1    = ov1 ? room1 : n1;
		room2 = room1 - c1;

		x1 = step_x_fn(x_q, cfg.step_x, ltr_q);
		x2 = step_x_fn(x1, cfg.step_x, ltr_q);

		lpf      = (cfg.lines_per_frame == '0) ? LINE_BITS'(1) : cfg.lines_per_frame;
		line_inc = line_q + LINE_BITS'(1);
		wrap     = (line_inc >= lpf);
		if (wrap) begin
			y_next = cfg.high_y;
		end else begin
			y_next = (y_q > cfg.step_y) ? sample_t'(y_q - cfg.step_y) : '0;
		end
	end

	always_comb begin
		runs[0] = '{x_sample: x_q, y_sample: y_q, repeat_count: c0, is_padding: 1'b0,
			frame_start: 1'b0, overflow: ov0, last: 1'b0};
		runs[1] = '{x_sample: x1, y_sample: y_q, repeat_count: c1, is_padding: 1'b0,
			frame_start: 1'b0, overflow: ov1, last: !line_done};
		runs[2] = '{x_sample: (ltr_q ? SAMPLE_MAX : '0), y_sample: y_q, repeat_count: room2,
			is_padding: 1'b1, frame_start: wrap, overflow: 1'b0, last: 1'b1};
		has_pad = line_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			used_q <= '0;
			x_q    <= SAMPLE_MAX;
			y_q    <= SAMPLE_MAX;
			line_q <= '0;
			ltr_q  <= 1'b0;
		end else if (load) begin
			if (!line_done) begin
				pos_q  <= pos_inc[POS_BITS-1:0];
				used_q <= used_q + c0 + c1;
				x_q    <= x2;
			end else begin
				pos_q  <= '0;
				used_q <= '0;
				line_q <= wrap ? '0 : line_inc;
				y_q    <= y_next;
				ltr_q  <= !ltr_q;
				x_q    <= ltr_q ? cfg.high_x : cfg.low_x;
			end
		end
	end

endmodule

// ----- rtl/core/sdrs_run_buf.sv -----
// sdrs_run_buf: result register holding the two or three runs of one byte,
// drained one beat per cycle while out_stall is low. Depends on sdrs_pkg.
module sdrs_run_buf
	import sdrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  run_t [2:0] runs,
	input  logic       has_pad,
	output logic       buf_free,
	output logic       out_valid,
	input  logic       out_stall,
	output run_t       run_out
);

	run_t [2:0] runs_q;
	logic       valid_q;
	logic       pad_q;
	logic [1:0] idx_q;
	logic       beat_done;
	logic       last_beat;

	assign beat_done = valid_q && !out_stall;
	assign last_beat = (idx_q == (pad_q ? 2'd2 : 2'd1));
	assign buf_free  = !valid_q || (beat_done && last_beat);
	assign out_valid = valid_q;

	always_comb begin
		case (idx_q)
			2'd0:    run_out = runs_q[0];
			2'd1:    run_out = runs_q[1];
			default: run_out = runs_q[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			runs_q <= runs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pad_q   <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			pad_q   <= has_pad;
			idx_q   <= '0;
		end else if (beat_done) begin
			if (last_beat) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/serpentine_dwell_raster_scan_unit.sv -----
// serpentine_dwell_raster_scan_unit: top level, input register and handshakes.
// Depends on sdrs_pkg, sdrs_cfg_regs, sdrs_run_core, sdrs_run_buf.
//
//   channel   | dir | handshake               | payload
//   ----------+-----+-------------------------+---------------------------------------
//   pixel in  | in  | in_valid / in_stall     | pixel_byte
//   run out   | out | out_valid / out_stall   | x_sample y_sample repeat_count
//             |     |                         | is_padding frame_start overflow last
//   config    | in  | cfg_valid / cfg_ready   | cfg_index cfg_data
//
// Each byte gives two run beats, three on the last byte of a line, and the
// single output port sets the sustained byte rate. A byte accepted passes
// the input register and then the result register, which presents its
// first beat. Reset returns all scan and handshake state to its initial
// values and loads register defaults. A stalled output holds its beat; the
// input register keeps taking the next byte while results drain.
module serpentine_dwell_raster_scan_unit
	import sdrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] pixel_byte,

	output logic       out_valid,
	input  logic       out_stall,
	output sample_t    x_sample,
	output sample_t    y_sample,
	output count_t     repeat_count,
	output logic       is_padding,
	output logic       frame_start,
	output logic       overflow,
	output logic       last,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  reg_idx_t   cfg_index,
	input  count_t     cfg_data
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] pix_s1;
	logic       buf_free;
	logic       load;
	run_t [2:0] runs;
	logic       has_pad;
	run_t       run_out;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	sdrs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// byte moves on to the result register once that is free or emptying
	assign load     = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pix_s1 <= pixel_byte;
		end
	end

	sdrs_run_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.load    (load),
		.pix     (pix_s1),
		.runs    (runs),
		.has_pad (has_pad)
	);

	sdrs_run_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.runs      (runs),
		.has_pad   (has_pad),
		.buf_free  (buf_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.run_out   (run_out)
	);

	assign x_sample     = run_out.x_sample;
	assign y_sample     = run_out.y_sample;
	assign repeat_count = run_out.repeat_count;
	assign is_padding   = run_out.is_padding;
	assign frame_start  = run_out.frame_start;
	assign overflow     = run_out.overflow;
	assign last         = run_out.last;

endmodule
